/* rtl/clf_pkg.sv */
// shared constants, codes and control types of the checked integer list fold
package clf_pkg;

	localparam int DATA_W = 64;
	localparam int HALF_W = DATA_W / 2;
	localparam int OP_W   = 2;
	localparam int ST_W   = 2;
	localparam int PATH_W = 2;

	localparam logic [DATA_W-1:0] SIGNED_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// operation codes
	localparam logic [OP_W-1:0] OP_ADD = 2'd0;
	localparam logic [OP_W-1:0] OP_SUB = 2'd1;
	localparam logic [OP_W-1:0] OP_MUL = 2'd2;
	localparam logic [OP_W-1:0] OP_DIV = 2'd3;

	// status codes
	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_TYPE = 2'd1;
	localparam logic [ST_W-1:0] ST_OVF  = 2'd2;
	localparam logic [ST_W-1:0] ST_DIV0 = 2'd3;

	// how the held item is processed
	localparam logic [PATH_W-1:0] PATH_QUICK = 2'd0;
	localparam logic [PATH_W-1:0] PATH_MUL   = 2'd1;
	localparam logic [PATH_W-1:0] PATH_DIV   = 2'd2;

	typedef struct packed {
		logic load_item;
		logic commit_quick;
		logic start_mul;
		logic commit_mul;
		logic start_div;
		logic commit_div;
		logic emit;
	} clf_cmd_t;

	typedef struct packed {
		logic [PATH_W-1:0] path;
		logic              mul_done;
		logic              div_done;
		logic              last;
	} clf_stat_t;

endpackage

/* rtl/clf_if.sv */
// valid/ready channels for operand items and fold results
interface clf_in_if;
	import clf_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          cmd;
	logic signed [DATA_W-1:0] operand_value;
	logic                     not_integer;
	logic                     last_operand;

	modport source (output valid, cmd, operand_value, not_integer, last_operand, input ready);
	modport sink (input valid, cmd, operand_value, not_integer, last_operand, output ready);
endinterface

interface clf_out_if;
	import clf_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] fold_result;
	logic [ST_W-1:0]          status;

	modport source (output valid, fold_result, status, input ready);
	modport sink (input valid, fold_result, status, output ready);
endinterface

/* rtl/clf_mul.sv */
// 64 by 64 wrapping multiply from three passes of one shared 32 by 32 multiplier
module clf_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [clf_pkg::DATA_W-1:0] a,
	input  logic [clf_pkg::DATA_W-1:0] b,
	output logic                       done,
	output logic [clf_pkg::DATA_W-1:0] product
);
	import clf_pkg::*;

	localparam logic [1:0] STEP_LL   = 2'd0;
	localparam logic [1:0] STEP_LH   = 2'd1;
	localparam logic [1:0] STEP_HL   = 2'd2;
	localparam logic [1:0] STEP_LAST = 2'd3;

	logic              busy_q;
	logic [1:0]        step_q;
	logic [DATA_W-1:0] a_q;
	logic [DATA_W-1:0] b_q;
	logic [DATA_W-1:0] lo_q;
	logic [HALF_W-1:0] cross_q;
	logic [HALF_W-1:0] op_x;
	logic [HALF_W-1:0] op_y;
	logic [DATA_W-1:0] prod;

	always_comb begin
		case (step_q)
			STEP_LL: begin
				op_x = a_q[HALF_W-1:0];
				op_y = b_q[HALF_W-1:0];
			end
			STEP_LH: begin
				op_x = a_q[HALF_W-1:0];
				op_y = b_q[DATA_W-1:HALF_W];
			end
			default: begin
				op_x = a_q[DATA_W-1:HALF_W];
				op_y = b_q[HALF_W-1:0];
			end
		endcase
	end

	assign prod = DATA_W'(op_x) * DATA_W'(op_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_LL;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_LL;
		end else if (busy_q) begin
			if (step_q == STEP_LAST) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			case (step_q)
				STEP_LL: lo_q <= prod;
				STEP_LH: cross_q <= prod[HALF_W-1:0];
				STEP_HL: cross_q <= cross_q + prod[HALF_W-1:0];
				default: ;
			endcase
		end
	end

	assign done    = busy_q && (step_q == STEP_LAST);
	assign product = lo_q + {cross_q, {HALF_W{1'b0}}};

endmodule

/* rtl/clf_div.sv */
// signed truncating divide, restoring shift-subtract one quotient bit per cycle
module clf_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [clf_pkg::DATA_W-1:0] dividend,
	input  logic [clf_pkg::DATA_W-1:0] divisor,
	output logic                       done,
	output logic [clf_pkg::DATA_W-1:0] quotient
);
	import clf_pkg::*;

	localparam int CNT_W = $clog2(DATA_W) + 1;

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DATA_W:0]   rem_q;
	logic [DATA_W:0]   rem_shift;
	logic [DATA_W:0]   rem_next;
	logic              ge;
	logic              last_step;
	logic [DATA_W-1:0] mag_n;
	logic [DATA_W-1:0] mag_d;

	assign mag_n = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
	assign mag_d = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;

	assign rem_shift = {rem_q[DATA_W-1:0], quo_q[DATA_W-1]};
	assign ge        = rem_shift >= {1'b0, dvs_q};
	assign rem_next  = ge ? (rem_shift - {1'b0, dvs_q}) : rem_shift;
	assign last_step = cnt_q == CNT_W'(DATA_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (last_step) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag_n;
			dvs_q <= mag_d;
			rem_q <= '0;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q && !last_step) begin
			quo_q <= {quo_q[DATA_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign done     = busy_q && last_step;
	assign quotient = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule

/* rtl/clf_dp.sv */
// datapath: held item, accumulator, error state, arithmetic units and result register
module clf_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  clf_pkg::clf_cmd_t                 ctl,
	output clf_pkg::clf_stat_t                stat,
	input  logic [clf_pkg::OP_W-1:0]          cmd,
	input  logic signed [clf_pkg::DATA_W-1:0] operand_value,
	input  logic                              not_integer,
	input  logic                              last_operand,
	output logic signed [clf_pkg::DATA_W-1:0] fold_result,
	output logic [clf_pkg::ST_W-1:0]          status
);
	import clf_pkg::*;

	logic [OP_W-1:0]   cmd_q;
	logic [DATA_W-1:0] val_q;
	logic              bad_q;
	logic              last_q;

	logic [DATA_W-1:0] acc_q;
	logic [OP_W-1:0]   op_q;
	logic [ST_W-1:0]   err_q;
	logic              first_q;

	logic [DATA_W-1:0] res_q;
	logic [ST_W-1:0]   st_q;

	logic [DATA_W-1:0] sum;
	logic [DATA_W-1:0] diff;
	logic              add_ovf;
	logic              sub_ovf;
	logic              div_zero;
	logic              div_ovf;
	logic [PATH_W-1:0] path;
	logic              mul_done;
	logic              div_done;
	logic [DATA_W-1:0] mul_prod;
	logic [DATA_W-1:0] div_quo;

	assign sum      = acc_q + val_q;
	assign diff     = acc_q - val_q;
	assign add_ovf  = (acc_q[DATA_W-1] == val_q[DATA_W-1]) && (sum[DATA_W-1] != acc_q[DATA_W-1]);
	assign sub_ovf  = (acc_q[DATA_W-1] != val_q[DATA_W-1]) && (diff[DATA_W-1] != acc_q[DATA_W-1]);
	assign div_zero = val_q == '0;
	assign div_ovf  = (acc_q == SIGNED_MIN) && (val_q == '1);

	always_comb begin
		path = PATH_QUICK;
		if (!first_q && (err_q == ST_OK) && !bad_q) begin
			case (op_q)
				OP_MUL: path = PATH_MUL;
				OP_DIV: path = (div_zero || div_ovf) ? PATH_QUICK : PATH_DIV;
				default: path = PATH_QUICK;
			endcase
		end
	end

	assign stat.path     = path;
	assign stat.mul_done = mul_done;
	assign stat.div_done = div_done;
	assign stat.last     = last_q;

	clf_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctl.start_mul),
		.a       (acc_q),
		.b       (val_q),
		.done    (mul_done),
		.product (mul_prod)
	);

	clf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.start_div),
		.dividend (acc_q),
		.divisor  (val_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			cmd_q  <= cmd;
			val_q  <= operand_value;
			bad_q  <= not_integer;
			last_q <= last_operand;
		end
		if (ctl.emit) begin
			res_q <= (err_q == ST_OK) ? acc_q : '0;
			st_q  <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			op_q    <= OP_ADD;
			err_q   <= ST_OK;
			first_q <= 1'b1;
		end else if (ctl.emit) begin
			// end of list: back to the fresh state
			acc_q   <= '0;
			op_q    <= OP_ADD;
			err_q   <= ST_OK;
			first_q <= 1'b1;
		end else if (ctl.commit_quick) begin
			if (first_q) begin
				op_q    <= cmd_q;
				first_q <= 1'b0;
				if (bad_q) begin
					err_q <= ST_TYPE;
					acc_q <= '0;
				end else begin
					acc_q <= val_q;
				end
			end else if (err_q == ST_OK) begin
				if (bad_q) begin
					err_q <= ST_TYPE;
				end else begin
					case (op_q)
						OP_ADD: begin
							if (add_ovf) err_q <= ST_OVF;
							else acc_q <= sum;
						end
						OP_SUB: begin
							if (sub_ovf) err_q <= ST_OVF;
							else acc_q <= diff;
						end
						OP_DIV: begin
							if (div_zero) err_q <= ST_DIV0;
							else if (div_ovf) err_q <= ST_OVF;
						end
						default: ;
					endcase
				end
			end
		end else if (ctl.commit_mul) begin
			acc_q <= mul_prod;
		end else if (ctl.commit_div) begin
			acc_q <= div_quo;
		end
	end

	assign fold_result = res_q;
	assign status      = st_q;

endmodule

/* rtl/clf_ctrl.sv */
// controller: item handshake, operation sequencing and result handshake
module clf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  clf_pkg::clf_stat_t stat,
	output clf_pkg::clf_cmd_t  ctl
);
	import clf_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_MUL    = 3'd2;
	localparam logic [2:0] S_DIV    = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load_item = 1'b1;
					state_d       = S_DECIDE;
				end
			end
			S_DECIDE: begin
				case (stat.path)
					PATH_MUL: begin
						ctl.start_mul = 1'b1;
						state_d       = S_MUL;
					end
					PATH_DIV: begin
						ctl.start_div = 1'b1;
						state_d       = S_DIV;
					end
					default: begin
						ctl.commit_quick = 1'b1;
						state_d          = S_DONE;
					end
				endcase
			end
			S_MUL: begin
				if (stat.mul_done) begin
					ctl.commit_mul = 1'b1;
					state_d        = S_DONE;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					ctl.commit_div = 1'b1;
					state_d        = S_DONE;
				end
			end
			S_DONE: begin
				// last item waits here until the result register is free
				if (!stat.last) begin
					state_d = S_IDLE;
				end else if (!out_valid_q || out_ready) begin
					ctl.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/checked_integer_list_fold.sv */
// Each item is loaded, then committed directly (a first item, add, subtract, a
// non-integer item, a divide by zero or minimum over minus one, or an item after an
// error), multiplied in three passes of the shared 32x32 multiplier, or divided in
// the shift-subtract divider at one quotient bit per cycle. No new item is taken
// until the previous one is done. A last item's result is registered once it commits,
// later while an earlier result is held. Reset clears the accumulator and error state.
module checked_integer_list_fold (
	input logic      clk,
	input logic      arst_n,
	clf_in_if.sink   operand,
	clf_out_if.source result
);
	import clf_pkg::*;

	clf_cmd_t  ctl;
	clf_stat_t stat;

	clf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operand.valid),
		.in_ready  (operand.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	clf_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.cmd           (operand.cmd),
		.operand_value (operand.operand_value),
		.not_integer   (operand.not_integer),
		.last_operand  (operand.last_operand),
		.fold_result   (result.fold_result),
		.status        (result.status)
	);

endmodule

/* test/tb_checked_integer_list_fold.sv */
// self-checking testbench for the checked integer list fold
module tb_checked_integer_list_fold;
	import clf_pkg::*;

	localparam logic [DATA_W-1:0] SIGNED_MAX = ~SIGNED_MIN;
	localparam int STALL_LIMIT = 3000;
	localparam int TAIL_CYCLES = 100;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [ST_W-1:0]   status;
	} fold_expect_t;

	logic clk = 1'b0;
	logic arst_n;

	clf_in_if  operand_ch ();
	clf_out_if result_ch ();

	checked_integer_list_fold DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.operand(operand_ch),
		.result (result_ch)
	);

	always #10 clk = ~clk;

	// running fold of the list in flight
	logic [DATA_W-1:0] fold_acc;
	logic [OP_W-1:0]   fold_op;
	logic [ST_W-1:0]   fold_err;
	logic              fold_first;

	fold_expect_t pending_folds[$];
	int fault_count = 0;
	int live_items = 0;
	int idle_cycles = 0;
	int tx_burst_left = 0;
	bit tx_idling = 1'b1;
	int rx_mode = 0;
	int rx_stall_left = 0;
	int rx_cycles = 0;

	function automatic logic [DATA_W-1:0] combine_step(input logic [OP_W-1:0] op,
			input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] x, output logic [ST_W-1:0] err);
		logic [DATA_W-1:0] s, ma, mx, q;
		err = ST_OK;
		s = a;
		case (op)
			OP_ADD: begin
				s = a + x;
				if (a[DATA_W-1] == x[DATA_W-1] && s[DATA_W-1] != a[DATA_W-1])
					err = ST_OVF;
			end
			OP_SUB: begin
				s = a - x;
				if (a[DATA_W-1] != x[DATA_W-1] && s[DATA_W-1] != a[DATA_W-1])
					err = ST_OVF;
			end
			OP_MUL: s = a * x;
			default: begin
				if (x == '0) begin
					err = ST_DIV0;
				end else if (a == SIGNED_MIN && x == '1) begin
					err = ST_OVF;
				end else begin
					ma = a[DATA_W-1] ? ('0 - a) : a;
					mx = x[DATA_W-1] ? ('0 - x) : x;
					q = ma / mx;
					// truncate toward zero
					s = (a[DATA_W-1] ^ x[DATA_W-1]) ? ('0 - q) : q;
				end
			end
		endcase
		return s;
	endfunction

	task automatic clear_fold();
		fold_acc = '0;
		fold_op = OP_ADD;
		fold_err = ST_OK;
		fold_first = 1'b1;
	endtask

	task automatic fold_operand(input logic [OP_W-1:0] cmd, input logic [DATA_W-1:0] value,
			input logic bad, input logic last);
		logic [DATA_W-1:0] next_acc;
		logic [ST_W-1:0] step_err;
		fold_expect_t exp_item;
		live_items++;
		if (fold_first) begin
			fold_op = cmd;
			fold_first = 1'b0;
			fold_acc = bad ? '0 : value;
			if (bad)
				fold_err = ST_TYPE;
		end else if (fold_err == ST_OK) begin
			if (bad) begin
				fold_err = ST_TYPE;
			end else begin
				next_acc = combine_step(fold_op, fold_acc, value, step_err);
				if (step_err != ST_OK)
					fold_err = step_err;
				else
					fold_acc = next_acc;
			end
		end
		if (last) begin
			exp_item.value = (fold_err == ST_OK) ? fold_acc : '0;
			exp_item.status = fold_err;
			pending_folds.push_back(exp_item);
			clear_fold();
		end
	endtask

	initial clear_fold();

	// accepted operand items feed the prediction
	always @(posedge clk) begin
		if (arst_n && operand_ch.valid && operand_ch.ready)
			fold_operand(operand_ch.cmd, operand_ch.operand_value, operand_ch.not_integer,
				operand_ch.last_operand);
	end

	always @(posedge clk) begin
		fold_expect_t exp_item;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_folds.size() == 0) begin
				fault_count++;
				$display("%0t: unexpected result, expected none, got value %0d status %0d",
					$time, $signed(result_ch.fold_result), result_ch.status);
			end else begin
				exp_item = pending_folds.pop_front();
				if (result_ch.fold_result !== exp_item.value) begin
					fault_count++;
					$display("%0t: fold_result mismatch, expected %0d, got %0d", $time,
						$signed(exp_item.value), $signed(result_ch.fold_result));
				end
				if (result_ch.status !== exp_item.status) begin
					fault_count++;
					$display("%0t: status mismatch, expected %0d, got %0d", $time,
						exp_item.status, result_ch.status);
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((operand_ch.valid && operand_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// receiver back-pressure in one of three randomly redrawn modes
	always @(negedge clk) begin
		logic rdy;
		rx_cycles++;
		if (rx_cycles % 300 == 0)
			rx_mode = $urandom_range(0, 2);
		case (rx_mode)
			0: rdy = 1'b1;
			1: rdy = ($urandom_range(0, 3) != 0);
			default: begin
				if (rx_stall_left > 0) begin
					rx_stall_left--;
					rdy = 1'b0;
				end else begin
					rdy = 1'b1;
					if ($urandom_range(0, 5) == 0)
						rx_stall_left = $urandom_range(1, 12);
				end
			end
		endcase
		result_ch.ready <= rdy;
	end

	task automatic send_item(input logic [OP_W-1:0] cmd, input logic [DATA_W-1:0] value,
			input logic bad, input logic last);
		int gap;
		@(negedge clk);
		if (tx_burst_left == 0) begin
			tx_burst_left = $urandom_range(1, 16);
			gap = tx_idling ? $urandom_range(0, 8) : 0;
			if (gap > 0) begin
				operand_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		tx_burst_left--;
		operand_ch.valid <= 1'b1;
		operand_ch.cmd <= cmd;
		operand_ch.operand_value <= value;
		operand_ch.not_integer <= bad;
		operand_ch.last_operand <= last;
		@(posedge clk);
		while (operand_ch.ready !== 1'b1)
			@(posedge clk);
	endtask

	task automatic idle_sender();
		@(negedge clk);
		operand_ch.valid <= 1'b0;
		tx_burst_left = 0;
	endtask

	task automatic wait_results_drained();
		idle_sender();
		while (pending_folds.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] rand_operand(input logic [OP_W-1:0] op, input bit later);
		logic [DATA_W-1:0] v;
		// small divisors keep divide lists alive longer
		if (op == OP_DIV && later && $urandom_range(0, 1))
			return 64'($urandom_range(0, 18)) - 64'd9;
		case ($urandom_range(0, 10))
			0: v = SIGNED_MIN;
			1: v = SIGNED_MAX;
			2: v = '0;
			3: v = '1;
			4: v = 64'd1;
			5, 6: v = 64'($urandom_range(0, 64)) - 64'd32;
			7: v = 64'($signed($urandom()));
			8: begin
				v = SIGNED_MAX - 64'($urandom_range(0, 3));
				if ($urandom_range(0, 1))
					v = ~v;
			end
			default: v = {$urandom(), $urandom()};
		endcase
		return v;
	endfunction

	task automatic send_random_list(input int len, input int bad_pct);
		logic [OP_W-1:0] op;
		op = OP_W'($urandom_range(0, 3));
		for (int k = 0; k < len; k++)
			send_item((k == 0) ? op : OP_W'($urandom_range(0, 3)), rand_operand(op, k > 0),
				$urandom_range(0, 99) < bad_pct, k == len - 1);
	endtask

	function automatic int rand_list_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
	endfunction

	task automatic test_directed();
		send_item(OP_ADD, SIGNED_MAX, 1'b0, 1'b1);
		send_item(OP_SUB, SIGNED_MIN, 1'b1, 1'b1);
		// add overflow in both directions
		send_item(OP_ADD, SIGNED_MAX, 1'b0, 1'b0);
		send_item(OP_ADD, 64'd1, 1'b0, 1'b1);
		send_item(OP_ADD, SIGNED_MIN, 1'b0, 1'b0);
		send_item(OP_ADD, '1, 1'b0, 1'b1);
		// subtract overflow in both directions
		send_item(OP_SUB, SIGNED_MIN, 1'b0, 1'b0);
		send_item(OP_SUB, 64'd1, 1'b0, 1'b1);
		send_item(OP_SUB, '0, 1'b0, 1'b0);
		send_item(OP_SUB, SIGNED_MIN, 1'b0, 1'b1);
		// multiply wraps
		send_item(OP_MUL, SIGNED_MAX, 1'b0, 1'b0);
		send_item(OP_MUL, SIGNED_MAX, 1'b0, 1'b1);
		// minimum over minus one
		send_item(OP_DIV, SIGNED_MIN, 1'b0, 1'b0);
		send_item(OP_DIV, '1, 1'b0, 1'b1);
		// truncation toward zero
		send_item(OP_DIV, -64'sd7, 1'b0, 1'b0);
		send_item(OP_DIV, 64'd2, 1'b0, 1'b1);
		send_item(OP_DIV, SIGNED_MAX, 1'b0, 1'b0);
		send_item(OP_DIV, SIGNED_MIN, 1'b0, 1'b1);
		// divide by zero, later items ignored
		send_item(OP_DIV, 64'd5, 1'b0, 1'b0);
		send_item(OP_DIV, '0, 1'b0, 1'b0);
		send_item(OP_ADD, 64'd3, 1'b0, 1'b1);
		// type error in the middle of a multiply list
		send_item(OP_MUL, 64'd3, 1'b0, 1'b0);
		send_item(OP_MUL, 64'd9, 1'b1, 1'b0);
		send_item(OP_DIV, 64'd4, 1'b0, 1'b1);
	endtask

	task automatic test_random_lists(input int target);
		int stop_at;
		stop_at = live_items + target;
		while (live_items < stop_at)
			send_random_list(rand_list_len(), 3);
	endtask

	task automatic test_error_lists(input int target);
		int stop_at;
		stop_at = live_items + target;
		while (live_items < stop_at)
			send_random_list($urandom_range(2, 10), $urandom_range(10, 40));
	endtask

	task automatic test_drained_lists(input int lists);
		for (int n = 0; n < lists; n++) begin
			send_random_list(rand_list_len(), 5);
			wait_results_drained();
		end
	endtask

	task automatic test_unthrottled(input int target);
		int stop_at;
		tx_idling = 1'b0;
		stop_at = live_items + target;
		while (live_items < stop_at)
			send_random_list(rand_list_len(), 3);
		tx_idling = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		operand_ch.valid = 1'b0;
		operand_ch.cmd = OP_ADD;
		operand_ch.operand_value = '0;
		operand_ch.not_integer = 1'b0;
		operand_ch.last_operand = 1'b0;
		result_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_lists(1200);
		test_error_lists(250);
		test_drained_lists(40);
		test_unthrottled(250);

		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
